FILE: design/mcm_pkg.sv
// Package: operation and status codes and the message entry type of the mailbox unit.
`timescale 1ns / 1ps
package mcm_pkg;
  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_OPEN    = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_SEND    = 3'd3,
    OP_RECEIVE = 3'd4,
    OP_DESTROY = 3'd5
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;
  localparam logic [15:0] REFS_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [15:0] mtype;
    logic [7:0]  msize;
    logic [15:0] sender;
    logic [63:0] payload;
  } msg_t;
endpackage

FILE: design/mcm_msg_mem.sv
// Message store: one synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mcm_msg_mem #(
  parameter int AW = 7
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  mcm_pkg::msg_t  wdata,
  input  logic [AW-1:0]  raddr,
  output mcm_pkg::msg_t  rdata
);
  import mcm_pkg::*;
  msg_t mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/multi_channel_mailbox_unit.sv
// Top level: mailbox channel table, sequencer and result register.
`timescale 1ns / 1ps
// Multi-channel mailbox unit.
// A request is taken when start is high and busy is low; its fields are the
// in_ ports. kind selects create, open, close, send, receive or destroy by
// owner. Every request gives exactly one result on the out_ ports, marked by
// done for one cycle; the receiver cannot stall it.
// In the accept cycle the block compares the id against all slot table
// entries (flip-flops) and issues one message RAM access; the result is then
// driven from the registered RAM read data. busy is high while done shows,
// so the next request is taken the cycle after done shows.
// Slot table updates land at the end of the accept cycle, so the next
// request sees them with no forwarding. Messages live in a CHANNELS*MESSAGES
// deep RAM with a registered read; an entry is only read after it was written.
// Reset frees all slots and sets the id counter to one; the RAM is not
// cleared.
module multi_channel_mailbox_unit #(
  parameter int CHANNELS = 8,
  parameter int MESSAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_channel_id,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_msg_type,
  input  logic [7:0]  in_msg_size,
  input  logic [15:0] in_sender_id,
  input  logic [63:0] in_payload,
  output logic        done,
  output logic [2:0]  out_status,
  output logic [31:0] out_new_channel_id,
  output logic [15:0] out_out_type,
  output logic [7:0]  out_out_size,
  output logic [15:0] out_out_sender,
  output logic [63:0] out_out_payload
);
  import mcm_pkg::*;
  localparam int SW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW = $clog2(MESSAGES);
  localparam int AW = SW + MW;

  logic [31:0]   ids_r   [CHANNELS];
  logic [15:0]   owner_r [CHANNELS];
  logic [15:0]   refs_r  [CHANNELS];
  logic [MW-1:0] head_r  [CHANNELS];
  logic [MW-1:0] tail_r  [CHANNELS];
  logic [31:0]   next_id_r;
  logic          phase_r;
  logic          rd_r;
  logic [2:0]    status_r;
  logic [31:0]   new_id_r;

  logic          accept;
  logic          hit, free_any;
  logic [SW-1:0] hs, fs;
  logic [MW-1:0] nt, nh;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  msg_t          wdata, rdata;
  logic [2:0]    status_nxt;
  logic [31:0]   id0, id_new;

  assign accept = start && !busy;
  assign busy   = phase_r;

  // Lowest matching and lowest free slot; the loop runs from the top down, so the lowest index wins.
  always_comb begin
    hit = 1'b0; hs = '0; free_any = 1'b0; fs = '0;
    for (int s = CHANNELS - 1; s >= 0; s--) begin
      if (in_channel_id != 32'd0 && ids_r[s] == in_channel_id) begin
        hit = 1'b1; hs = SW'(s);
      end
      if (ids_r[s] == 32'd0) begin
        free_any = 1'b1; fs = SW'(s);
      end
    end
  end

  // Advance ring pointers, wrapping at the ring depth.
  assign nt     = (tail_r[hs] == MW'(MESSAGES - 1)) ? '0 : tail_r[hs] + MW'(1);
  assign nh     = (head_r[hs] == MW'(MESSAGES - 1)) ? '0 : head_r[hs] + MW'(1);
  assign id0    = next_id_r;
  assign id_new = (id0 == 32'd0) ? 32'd1 : id0;
  assign wdata  = '{mtype: in_msg_type, msize: in_msg_size,
                    sender: in_sender_id, payload: in_payload};
  assign we     = accept && in_kind == OP_SEND && hit && nt != head_r[hs];
  assign waddr  = {hs, tail_r[hs]};
  assign raddr  = {hs, head_r[hs]};

  always_comb begin
    status_nxt = ST_OK;
    unique case (in_kind)
      OP_CREATE:  if (!free_any) status_nxt = ST_NO_SLOT;
      OP_OPEN, OP_CLOSE: if (!hit) status_nxt = ST_NOT_FOUND;
      OP_SEND:    if (!hit) status_nxt = ST_NOT_FOUND;
                  else if (nt == head_r[hs]) status_nxt = ST_FULL;
      OP_RECEIVE: if (!hit) status_nxt = ST_NOT_FOUND;
                  else if (head_r[hs] == tail_r[hs]) status_nxt = ST_EMPTY;
      default:    status_nxt = ST_OK;
    endcase
  end

  mcm_msg_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Slot table read-modify-write, all in the accept cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < CHANNELS; s++) begin
        ids_r[s] <= '0; owner_r[s] <= '0; refs_r[s] <= '0;
        head_r[s] <= '0; tail_r[s] <= '0;
      end
      next_id_r <= 32'd1;
      phase_r   <= 1'b0;
      rd_r      <= 1'b0;
    end else begin
      phase_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
        new_id_r <= '0;
        rd_r     <= in_kind == OP_RECEIVE && status_nxt == ST_OK;
        unique case (in_kind)
          OP_CREATE: if (free_any) begin
            ids_r[fs] <= id_new; owner_r[fs] <= in_process_id; refs_r[fs] <= 16'd1;
            head_r[fs] <= '0; tail_r[fs] <= '0;
            new_id_r  <= id_new;
            next_id_r <= id_new + 32'd1;
          end
          OP_OPEN: if (hit && refs_r[hs] != REFS_MAX) refs_r[hs] <= refs_r[hs] + 16'd1;
          OP_CLOSE: if (hit) begin
            if (refs_r[hs] != 16'd0) refs_r[hs] <= refs_r[hs] - 16'd1;
            if (refs_r[hs] <= 16'd1) ids_r[hs] <= '0;
          end
          OP_SEND: if (we) tail_r[hs] <= nt;
          OP_RECEIVE: if (status_nxt == ST_OK) head_r[hs] <= nh;
          OP_DESTROY:
            for (int s = 0; s < CHANNELS; s++)
              if (ids_r[s] != 32'd0 && owner_r[s] == in_process_id) begin
                ids_r[s] <= '0; refs_r[s] <= '0;
              end
          default: ;
        endcase
      end
    end
  end

  // Result: hold message fields at zero unless a receive succeeded.
  assign done               = phase_r;
  assign out_status         = status_r;
  assign out_new_channel_id = new_id_r;
  assign out_out_type       = rd_r ? rdata.mtype   : '0;
  assign out_out_size       = rd_r ? rdata.msize   : '0;
  assign out_out_sender     = rd_r ? rdata.sender  : '0;
  assign out_out_payload    = rd_r ? rdata.payload : '0;

  a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> done) else $error("request gave no result");
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("result repeated");
  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    done && out_new_channel_id != 32'd0 |-> out_status == ST_OK)
    else $error("id given with bad status");
endmodule

FILE: tb/sv/multi_channel_mailbox_unit_test.sv
// Testbench: mailbox unit checked request by request against a behavioral predictor.
`timescale 1ns / 1ps
// Self-checking bench for the multi-channel mailbox unit.
// An initial block builds the whole request list: a directed part first, then
// random traffic in phases with different sender idle rates. A clocked driver
// pops requests into the block. Each request the block takes runs through the
// predictor, which keeps its own slot table and message rings. A clocked
// monitor checks every done strobe against the oldest predicted result.
module multi_channel_mailbox_unit_test;
  import mcm_pkg::*;

  localparam int NCHAN = 8;
  localparam int NMSG  = 16;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] chan;
    logic [15:0] pid;
    msg_t        msg;
    int          idle_pct;
  } mbox_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] new_id;
    msg_t        msg;
  } mbox_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_channel_id = '0;
  logic [15:0] in_process_id = '0;
  logic [15:0] in_msg_type = '0;
  logic [7:0]  in_msg_size = '0;
  logic [15:0] in_sender_id = '0;
  logic [63:0] in_payload = '0;
  logic        busy, done;
  logic [2:0]  out_status;
  logic [31:0] out_new_channel_id;
  logic [15:0] out_out_type;
  logic [7:0]  out_out_size;
  logic [15:0] out_out_sender;
  logic [63:0] out_out_payload;

  multi_channel_mailbox_unit dut (.*);

  always #5 clk = ~clk;

  // Predictor state: a private copy of the slot table and rings.
  logic [31:0] tbl_id    [NCHAN];
  logic [15:0] tbl_owner [NCHAN];
  logic [15:0] tbl_refs  [NCHAN];
  logic [3:0]  tbl_head  [NCHAN];
  logic [3:0]  tbl_tail  [NCHAN];
  msg_t        ring_mem  [NCHAN*NMSG];
  logic [31:0] id_counter;

  mbox_req_t pending_reqs[$];
  mbox_rsp_t predicted_rsps[$];
  int errors = 0;
  int taken = 0;
  int status_seen[5];

  // Lowest slot holding this id, -1 if none or id zero.
  function automatic int find_slot(logic [31:0] id);
    if (id == 0) return -1;
    for (int s = 0; s < NCHAN; s++)
      if (tbl_id[s] == id) return s;
    return -1;
  endfunction

  function automatic mbox_rsp_t mailbox_predict(mbox_req_t r);
    mbox_rsp_t  p;
    int         s;
    logic [3:0] nt;
    p = '{status: ST_OK, new_id: '0, msg: '0};
    s = (r.kind inside {OP_OPEN, OP_CLOSE, OP_SEND, OP_RECEIVE}) ? find_slot(r.chan) : -1;
    case (r.kind)
      OP_CREATE: begin
        p.status = ST_NO_SLOT;
        for (int k = 0; k < NCHAN; k++) begin
          if (tbl_id[k] == 0) begin
            if (id_counter == 0) id_counter++;
            tbl_id[k] = id_counter;
            id_counter++;
            tbl_owner[k] = r.pid;
            tbl_refs[k] = 16'd1;
            tbl_head[k] = '0;
            tbl_tail[k] = '0;
            p.new_id = tbl_id[k];
            p.status = ST_OK;
            break;
          end
        end
      end
      OP_OPEN: begin
        if (s < 0) p.status = ST_NOT_FOUND;
        else if (tbl_refs[s] != REFS_MAX) tbl_refs[s]++;
      end
      OP_CLOSE: begin
        if (s < 0) p.status = ST_NOT_FOUND;
        else begin
          if (tbl_refs[s] != 0) tbl_refs[s]--;
          if (tbl_refs[s] == 0) tbl_id[s] = '0;
        end
      end
      OP_SEND: begin
        if (s < 0) p.status = ST_NOT_FOUND;
        else begin
          nt = tbl_tail[s] + 4'd1;
          if (nt == tbl_head[s]) p.status = ST_FULL;
          else begin
            ring_mem[s*NMSG + tbl_tail[s]] = r.msg;
            tbl_tail[s] = nt;
          end
        end
      end
      OP_RECEIVE: begin
        if (s < 0) p.status = ST_NOT_FOUND;
        else if (tbl_head[s] == tbl_tail[s]) p.status = ST_EMPTY;
        else begin
          p.msg = ring_mem[s*NMSG + tbl_head[s]];
          tbl_head[s] = tbl_head[s] + 4'd1;
        end
      end
      OP_DESTROY: begin
        for (int k = 0; k < NCHAN; k++)
          if (tbl_id[k] != 0 && tbl_owner[k] == r.pid) begin
            tbl_id[k] = '0;
            tbl_refs[k] = '0;
          end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic mbox_req_t make_req(logic [2:0] kind, logic [31:0] chan,
                                         logic [15:0] pid, int idle_pct);
    mbox_req_t r;
    r.kind = kind;
    r.chan = chan;
    r.pid = pid;
    r.msg.mtype = $urandom;
    r.msg.msize = $urandom;
    r.msg.sender = $urandom;
    r.msg.payload = {$urandom, $urandom};
    r.idle_pct = idle_pct;
    return r;
  endfunction

  // Driver: retire the request the block took, then present the next one
  // or hold off for an idle cycle.
  always @(posedge clk) begin : driver
    logic      go;
    mbox_req_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r = pending_reqs.pop_front();
        predicted_rsps.push_back(mailbox_predict(r));
        taken++;
      end
      go = 1'b0;
      if (pending_reqs.size() > 0) begin
        r = pending_reqs[0];
        go = ($urandom_range(0, 99) >= r.idle_pct);
        if (go) begin
          in_kind <= r.kind;
          in_channel_id <= r.chan;
          in_process_id <= r.pid;
          in_msg_type <= r.msg.mtype;
          in_msg_size <= r.msg.msize;
          in_sender_id <= r.msg.sender;
          in_payload <= r.msg.payload;
        end
      end
      start <= go;
    end
  end

  // Monitor: check each strobe against the oldest prediction.
  always @(posedge clk) begin : monitor
    mbox_rsp_t e;
    if (rst_n && done) begin
      if (predicted_rsps.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, out_status);
        errors++;
      end else begin
        e = predicted_rsps.pop_front();
        if (e.status < 5) status_seen[e.status]++;
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_new_channel_id !== e.new_id) begin
          $display("%0t: new id exp %h got %h", $time, e.new_id, out_new_channel_id);
          errors++;
        end
        if (out_out_type !== e.msg.mtype) begin
          $display("%0t: type exp %h got %h", $time, e.msg.mtype, out_out_type);
          errors++;
        end
        if (out_out_size !== e.msg.msize) begin
          $display("%0t: size exp %h got %h", $time, e.msg.msize, out_out_size);
          errors++;
        end
        if (out_out_sender !== e.msg.sender) begin
          $display("%0t: sender exp %h got %h", $time, e.msg.sender, out_out_sender);
          errors++;
        end
        if (out_out_payload !== e.msg.payload) begin
          $display("%0t: payload exp %h got %h", $time, e.msg.payload, out_out_payload);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int          creates;
    int          pick;
    int          idle;
    logic [2:0]  kind;
    logic [31:0] chan;
    logic [15:0] pid;
    for (int s = 0; s < NCHAN; s++) begin
      tbl_id[s] = '0;
      tbl_owner[s] = '0;
      tbl_refs[s] = '0;
      tbl_head[s] = '0;
      tbl_tail[s] = '0;
    end
    id_counter = 32'd1;

    // Directed: unknown and zero ids on an empty table, every opcode,
    // unused opcodes, extreme field values.
    pending_reqs.push_back(make_req(OP_OPEN, 32'd0, 16'd0, 0));
    pending_reqs.push_back(make_req(OP_SEND, 32'hFFFF_FFFF, 16'hFFFF, 0));
    pending_reqs.push_back(make_req(OP_RECEIVE, 32'd1, 16'd0, 0));
    pending_reqs.push_back(make_req(OP_CLOSE, 32'd1, 16'd0, 0));
    pending_reqs.push_back(make_req(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 0));
    pending_reqs.push_back(make_req(3'd7, 32'd5, 16'd5, 0));
    pending_reqs.push_back(make_req(OP_DESTROY, 32'd0, 16'd9, 0));
    // Fill the table, then one create too many.
    for (int i = 0; i < NCHAN + 1; i++)
      pending_reqs.push_back(make_req(OP_CREATE, '0, (i == 0) ? 16'hFFFF : 16'(i % 3), 0));
    creates = NCHAN;
    // Fill channel 1 to full, one more send is refused, drain past empty.
    for (int i = 0; i < NMSG; i++)
      pending_reqs.push_back(make_req(OP_SEND, 32'd1, '0, 0));
    pending_reqs[pending_reqs.size()-1].msg = '1;
    for (int i = 0; i < NMSG; i++)
      pending_reqs.push_back(make_req(OP_RECEIVE, 32'd1, '0, 0));
    // Open a few times, then close twice.
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(OP_OPEN, 32'd2, '0, 0));
    pending_reqs.push_back(make_req(OP_CLOSE, 32'd2, '0, 0));
    pending_reqs.push_back(make_req(OP_CLOSE, 32'd2, '0, 0));
    // Close channel 3 to zero refs, which frees it; then it is not found.
    pending_reqs.push_back(make_req(OP_CLOSE, 32'd3, '0, 0));
    pending_reqs.push_back(make_req(OP_SEND, 32'd3, '0, 0));
    pending_reqs.push_back(make_req(OP_DESTROY, '0, 16'hFFFF, 0));
    pending_reqs.push_back(make_req(OP_CREATE, '0, 16'd1, 0));
    creates++;

    // Random traffic, mostly on live recent ids, in four idle phases.
    for (int i = 0; i < 700; i++) begin
      case (i * 4 / 700)
        0: idle = 0;
        1: idle = 54;
        2: idle = 0;
        default: idle = 21;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 12) kind = OP_CREATE;
      else if (pick < 20) kind = OP_OPEN;
      else if (pick < 28) kind = OP_CLOSE;
      else if (pick < 60) kind = OP_SEND;
      else if (pick < 90) kind = OP_RECEIVE;
      else if (pick < 96) kind = OP_DESTROY;
      else kind = 3'($urandom_range(6, 7));
      if (kind == OP_CREATE) creates++;
      pick = $urandom_range(0, 99);
      if (pick < 85) chan = $urandom_range(creates > 8 ? creates - 8 : 1, creates);
      else if (pick < 92) chan = '0;
      else chan = $urandom;
      pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      pending_reqs.push_back(make_req(kind, chan, pid, idle));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && predicted_rsps.size() == 0);
    repeat (10) @(posedge clk);
    $display("run covered %0d requests: ok %0d, not found %0d, full %0d, empty %0d,",
             taken, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    $display("no free slot %0d, with ring wrap, slot reuse and idle-rate phases",
             status_seen[ST_NO_SLOT]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
